// ----- hw/rtl/cftlp_pkg.sv -----
// ----------------------------------------------------------------------------
// cftlp_pkg
// Shared types and constants for the frame text line parser.
// ----------------------------------------------------------------------------
package cftlp_pkg;

  localparam logic [10:0] IdAMax  = 11'h7ff;
  localparam logic [17:0] IdBMax  = 18'h3ffff;
  localparam logic [15:0] CrcPoly = 16'hc599;

  localparam logic [1:0] StatusOk    = 2'd0;
  localparam logic [1:0] StatusError = 2'd1;
  localparam logic [1:0] StatusFlood = 2'd2;

  localparam logic RegDefaultPort = 1'b0;
  localparam logic RegFloodLimit  = 1'b1;

  // parser phases
  typedef enum logic [3:0] {
    PH_IDA, PH_IDB, PH_AFTER_IDB, PH_AFTER_R, PH_PAY, PH_AFTER_PAY,
    PH_CHK, PH_AFTER_CHK, PH_PORT, PH_DONE, PH_ERR
  } phase_t;

  // controller -> datapath
  typedef struct packed {
    logic step;      // feed the held byte through one parse step
    logic term;      // held byte is a line end
    logic clear;     // start a new line
    logic crc_start; // load CRC engine
    logic crc_bit;   // one CRC bit step
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic again;     // parse step fell through to the next phase
    logic crc_req;   // check field complete, CRC needed
    logic crc_done;  // all CRC bits consumed
  } dp_stat_t;

  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) r = {1'b1, c[3:0]};
    else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
      r = {1'b1, c[3:0] + 4'd9};
    return r;
  endfunction

endpackage

// ----- hw/rtl/can_frame_text_line_parser.sv -----
// ----------------------------------------------------------------------------
// can_frame_text_line_parser
// Parses text lines into frame words with payload, CRC check and port.
// ----------------------------------------------------------------------------
//  channel  | handshake              | payload
//  in       | in_valid / in_stall    | in_byte
//  out      | out_valid / out_stall  | status port header payload_len payload
//           |                        | line_bytes
//  cfg      | cfg_valid / cfg_ready  | cfg_index cfg_data
//
// A byte goes through intake and parse steps, then an emit step when it ends
// a line or floods; a line end on an empty line is only taken in. The byte
// that closes a check field also runs the bit-serial CRC.
// Reset clears the parse state; registers return to default_port 3 and
// flood_limit 96. A stalled result holds intake off until it is taken.
// ----------------------------------------------------------------------------
module can_frame_text_line_parser #(
  parameter int PAYLOAD_BYTES = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [2:0]  port,
  output logic [31:0] header,
  output logic [3:0]  payload_len,
  output logic [63:0] payload,
  output logic [8:0]  line_bytes,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  cftlp_pkg::dp_cmd_t  cmd;
  cftlp_pkg::dp_stat_t stat;
  logic [2:0]  default_port;
  logic [7:0]  flood_limit;
  logic [7:0]  c;
  logic        error_flag;
  logic [2:0]  port_value;
  logic [31:0] header_word;
  logic [3:0]  payload_count;
  logic [63:0] payload_store;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      default_port <= 3'd3;
      flood_limit  <= 8'd96;
    end else if (cfg_valid) begin
      case (cfg_index)
        cftlp_pkg::RegDefaultPort: default_port <= cfg_data[2:0];
        cftlp_pkg::RegFloodLimit:  flood_limit  <= cfg_data;
        default: ;
      endcase
    end
  end

  cftlp_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .in_byte, .out_valid, .out_stall,
    .flood_limit, .default_port, .cmd, .stat, .c, .error_flag, .port_value,
    .header_word, .payload_count, .payload_store, .status, .port, .header,
    .payload_len, .payload, .line_bytes
  );

  cftlp_datapath #(.PAYLOAD_BYTES(PAYLOAD_BYTES)) u_dp (
    .clk, .rst, .cmd, .stat, .c, .default_port, .error_flag, .port_value,
    .header_word, .payload_count, .payload_store
  );

endmodule

// ----- hw/rtl/cftlp_datapath.sv -----
// ----------------------------------------------------------------------------
// cftlp_datapath
// Line parse state, field accumulators and bit-serial CRC engine.
// ----------------------------------------------------------------------------
module cftlp_datapath #(
  parameter int PAYLOAD_BYTES = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  cftlp_pkg::dp_cmd_t    cmd,
  output cftlp_pkg::dp_stat_t   stat,
  input  logic [7:0]            c,
  input  logic [2:0]            default_port,
  output logic                  error_flag,
  output logic [2:0]            port_value,
  output logic [31:0]           header_word,
  output logic [3:0]            payload_count,
  output logic [63:0]           payload_store
);

  localparam logic [3:0] PayMax = 4'(PAYLOAD_BYTES);

  cftlp_pkg::phase_t phase, phase_next;
  logic [3:0]  digit_count, digit_count_next;
  logic [11:0] id_a_value, id_a_value_next;
  logic [18:0] id_b_value, id_b_value_next;
  logic        ext_flag, ext_flag_next, rtr_flag, rtr_flag_next;
  logic [63:0] payload_store_next;
  logic [3:0]  payload_count_next;
  logic [4:0]  nibble_hold, nibble_hold_next;
  logic [15:0] check_value, check_value_next;
  logic [2:0]  port_value_next;
  logic        error_flag_next;
  logic        again, crc_req;
  logic [4:0]  d;

  // CRC engine: shifts a bit stream of header, payload, check
  logic [15:0]  crc;
  logic [127:0] crc_stream;
  logic [127:0] crc_load;
  logic [6:0]   crc_left;

  assign d = cftlp_pkg::hex_val(c);
  assign header_word = {id_a_value[10:0], id_b_value[17:0], ext_flag, rtr_flag, 1'b0};

  always_comb begin
    phase_next         = phase;
    digit_count_next   = digit_count;
    id_a_value_next    = id_a_value;
    id_b_value_next    = id_b_value;
    ext_flag_next      = ext_flag;
    rtr_flag_next      = rtr_flag;
    payload_store_next = payload_store;
    payload_count_next = payload_count;
    nibble_hold_next   = nibble_hold;
    check_value_next   = check_value;
    port_value_next    = port_value;
    error_flag_next    = error_flag;
    again   = 1'b0;
    crc_req = 1'b0;
    case (phase)
      cftlp_pkg::PH_IDA: begin
        if (d[4] && !cmd.term && digit_count < 4'd8) begin
          if (!id_a_value[11]) begin
            // any of bits 10:8 set already overflows after the shift
            if (id_a_value[10:8] != 3'd0 ||
                {id_a_value[7:0], d[3:0]} > {1'b0, cftlp_pkg::IdAMax})
              id_a_value_next = 12'h800;
            else
              id_a_value_next = {id_a_value[7:0], d[3:0]};
          end
          digit_count_next = digit_count + 4'd1;
        end else if (digit_count == 4'd0 || id_a_value == 12'd0 || id_a_value[11]) begin
          phase_next = cftlp_pkg::PH_ERR;
          error_flag_next = 1'b1;
        end else if (!cmd.term && c == 8'h2e) begin
          phase_next = cftlp_pkg::PH_IDB;
          digit_count_next = 4'd0;
        end else begin
          phase_next = cftlp_pkg::PH_AFTER_IDB;
          again = 1'b1;
        end
      end
      cftlp_pkg::PH_IDB: begin
        if (d[4] && !cmd.term && digit_count < 4'd8) begin
          if (!id_b_value[18]) begin
            if (id_b_value[17:15] != 3'd0 ||
                {id_b_value[14:0], d[3:0]} > {1'b0, cftlp_pkg::IdBMax})
              id_b_value_next = 19'h40000;
            else
              id_b_value_next = {id_b_value[14:0], d[3:0]};
          end
          digit_count_next = digit_count + 4'd1;
        end else if (digit_count == 4'd0 || id_b_value[18]) begin
          phase_next = cftlp_pkg::PH_ERR;
          error_flag_next = 1'b1;
        end else begin
          ext_flag_next = 1'b1;
          phase_next = cftlp_pkg::PH_AFTER_IDB;
          again = 1'b1;
        end
      end
      cftlp_pkg::PH_AFTER_IDB: begin
        phase_next = cftlp_pkg::PH_AFTER_R;
        if (!cmd.term && c == 8'h52) rtr_flag_next = 1'b1;
        else again = 1'b1;
      end
      cftlp_pkg::PH_AFTER_R: begin
        if (!cmd.term && c == 8'h3a) phase_next = cftlp_pkg::PH_PAY;
        else begin
          phase_next = cftlp_pkg::PH_AFTER_PAY;
          again = 1'b1;
        end
      end
      cftlp_pkg::PH_PAY: begin
        if (nibble_hold[4]) begin
          if (!d[4] || cmd.term) begin
            phase_next = cftlp_pkg::PH_ERR;
            error_flag_next = 1'b1;
          end else begin
            payload_store_next[payload_count[2:0]*8 +: 8] = {nibble_hold[3:0], d[3:0]};
            payload_count_next = payload_count + 4'd1;
            nibble_hold_next = 5'd0;
          end
        end else if (d[4] && !cmd.term) begin
          if (payload_count >= PayMax) begin
            phase_next = cftlp_pkg::PH_ERR;
            error_flag_next = 1'b1;
          end else nibble_hold_next = d;
        end else begin
          phase_next = cftlp_pkg::PH_AFTER_PAY;
          again = 1'b1;
        end
      end
      cftlp_pkg::PH_AFTER_PAY: begin
        if (!cmd.term && c == 8'h3a) begin
          phase_next = cftlp_pkg::PH_CHK;
          digit_count_next = 4'd0;
          check_value_next = 16'd0;
        end else begin
          phase_next = cftlp_pkg::PH_AFTER_CHK;
          again = 1'b1;
        end
      end
      cftlp_pkg::PH_CHK: begin
        if (d[4] && !cmd.term) begin
          if (digit_count >= 4'd4) begin
            phase_next = cftlp_pkg::PH_ERR;
            error_flag_next = 1'b1;
          end else begin
            check_value_next = {check_value[11:0], d[3:0]};
            digit_count_next = digit_count + 4'd1;
          end
        end else if (digit_count != 4'd4) begin
          phase_next = cftlp_pkg::PH_ERR;
          error_flag_next = 1'b1;
        end else begin
          // controller runs the CRC, then resumes from PH_AFTER_CHK (PH_ERR if the CRC fails)
          crc_req = 1'b1;
          phase_next = cftlp_pkg::PH_AFTER_CHK;
        end
      end
      cftlp_pkg::PH_AFTER_CHK: begin
        phase_next = (!cmd.term && c == 8'h20) ? cftlp_pkg::PH_PORT : cftlp_pkg::PH_DONE;
      end
      cftlp_pkg::PH_PORT: begin
        if (!cmd.term && c >= 8'h30 && c <= 8'h37) port_value_next = c[2:0];
        phase_next = cftlp_pkg::PH_DONE;
      end
      default: ;
    endcase
  end

  assign stat.again    = again;
  assign stat.crc_req  = crc_req;
  assign stat.crc_done = (crc_left == 7'd0);

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      phase         <= cftlp_pkg::PH_IDA;
      digit_count   <= 4'd0;
      id_a_value    <= 12'd0;
      id_b_value    <= 19'd0;
      ext_flag      <= 1'b0;
      rtr_flag      <= 1'b0;
      payload_store <= 64'd0;
      payload_count <= 4'd0;
      nibble_hold   <= 5'd0;
      check_value   <= 16'd0;
      port_value    <= default_port;
      error_flag    <= 1'b0;
    end else if (cmd.step) begin
      phase         <= phase_next;
      digit_count   <= digit_count_next;
      id_a_value    <= id_a_value_next;
      id_b_value    <= id_b_value_next;
      ext_flag      <= ext_flag_next;
      rtr_flag      <= rtr_flag_next;
      payload_store <= payload_store_next;
      payload_count <= payload_count_next;
      nibble_hold   <= nibble_hold_next;
      check_value   <= check_value_next;
      port_value    <= port_value_next;
      error_flag    <= error_flag_next;
    end else if (cmd.crc_bit && crc_left == 7'd0 && crc != 16'd0) begin
      phase      <= cftlp_pkg::PH_ERR;
      error_flag <= 1'b1;
    end
  end

  // header (32) + payload bytes + check (16), msb first; bytes in line order.
  // Bytes beyond the count are zero, so the check word is ORed in after them.
  assign crc_load = {header_word,
                     payload_store[7:0],   payload_store[15:8],
                     payload_store[23:16], payload_store[31:24],
                     payload_store[39:32], payload_store[47:40],
                     payload_store[55:48], payload_store[63:56], 32'd0} |
                    ({32'd0, check_value, 80'd0} >> {payload_count, 3'b000});

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_left <= 7'd0;
    end else if (cmd.crc_start) begin
      crc        <= 16'd0;
      crc_stream <= crc_load;
      crc_left   <= 7'd48 + {payload_count, 3'b000};
    end else if (cmd.crc_bit && crc_left != 7'd0) begin
      crc        <= ({crc[14:0], 1'b0}) ^
                    (((crc[15] ^ crc_stream[127]) != 1'b0) ? {cftlp_pkg::CrcPoly[14:0], 1'b0} ^
                     16'd0 : 16'd0) ^ 16'd0;
      crc_stream <= {crc_stream[126:0], 1'b0};
      crc_left   <= crc_left - 7'd1;
    end
  end

endmodule

// ----- hw/rtl/cftlp_ctrl.sv -----
// ----------------------------------------------------------------------------
// cftlp_ctrl
// Sequencer: byte intake, parse steps, CRC bit loop and result emission.
// ----------------------------------------------------------------------------
module cftlp_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [7:0]           in_byte,
  output logic                 out_valid,
  input  logic                 out_stall,
  input  logic [7:0]           flood_limit,
  input  logic [2:0]           default_port,
  output cftlp_pkg::dp_cmd_t   cmd,
  input  cftlp_pkg::dp_stat_t  stat,
  output logic [7:0]           c,
  input  logic                 error_flag,
  input  logic [2:0]           port_value,
  input  logic [31:0]          header_word,
  input  logic [3:0]           payload_count,
  input  logic [63:0]          payload_store,
  output logic [1:0]           status,
  output logic [2:0]           port,
  output logic [31:0]          header,
  output logic [3:0]           payload_len,
  output logic [63:0]          payload,
  output logic [8:0]           line_bytes
);

  typedef enum logic [2:0] {S_IDLE, S_PARSE, S_CRC, S_EMIT} state_t;

  state_t      state;
  logic        term;
  logic [8:0]  line_count;
  logic        accept, out_free;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != S_IDLE) || !out_free;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    cmd = '0;
    cmd.term = term;
    case (state)
      S_PARSE: cmd.step = 1'b1;
      S_CRC:   cmd.crc_bit = 1'b1;
      default: ;
    endcase
    if (state == S_PARSE && stat.crc_req) cmd.crc_start = 1'b1;
    if (accept && line_count == 9'd0 && in_byte != 8'h0a && in_byte != 8'h0d)
      cmd.clear = 1'b1;
    if (state == S_EMIT) cmd.clear = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      out_valid  <= 1'b0;
      line_count <= 9'd0;
      term       <= 1'b0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            c <= in_byte;
            if (in_byte == 8'h0a || in_byte == 8'h0d) begin
              if (line_count != 9'd0) begin
                term  <= 1'b1;
                state <= S_PARSE;
              end
            end else begin
              term       <= 1'b0;
              line_count <= line_count + 9'd1;
              state      <= S_PARSE;
            end
          end
        end
        S_PARSE: begin
          if (stat.crc_req) state <= S_CRC;
          else if (!stat.again) begin
            if (term || line_count > {1'b0, flood_limit}) state <= S_EMIT;
            else state <= S_IDLE;
          end
        end
        S_CRC: begin
          if (stat.crc_done) state <= S_PARSE;
        end
        S_EMIT: begin
          // last parse step has settled; the datapath is cleared at this edge
          state       <= S_IDLE;
          out_valid   <= 1'b1;
          line_count  <= 9'd0;
          if (term) begin
            status      <= error_flag ? cftlp_pkg::StatusError : cftlp_pkg::StatusOk;
            line_bytes  <= line_count + 9'd1;
          end else begin
            status      <= cftlp_pkg::StatusFlood;
            line_bytes  <= line_count;
          end
          if (term && !error_flag) begin
            port        <= port_value;
            header      <= header_word;
            payload_len <= payload_count;
            payload     <= payload_store;
          end else begin
            port        <= default_port;
            header      <= 32'd0;
            payload_len <= 4'd0;
            payload     <= 64'd0;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- bench/can_frame_text_line_parser_tb.sv -----
// ----------------------------------------------------------------------------
// can_frame_text_line_parser_tb
// Drives text lines into the parser and checks every result against a
// behavioural parser model, with random input gaps and output stalls.
// ----------------------------------------------------------------------------
module can_frame_text_line_parser_tb;

  typedef struct packed {
    logic [1:0]  status;
    logic [2:0]  port;
    logic [31:0] header;
    logic [3:0]  payload_len;
    logic [63:0] payload;
    logic [8:0]  line_bytes;
  } frame_res_t;

  typedef struct {
    logic [7:0]  ch;
    logic        has_exp;
    frame_res_t  res;
  } row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  status;
  logic [2:0]  port;
  logic [31:0] header;
  logic [3:0]  payload_len;
  logic [63:0] payload;
  logic [8:0]  line_bytes;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [0:0]  cfg_index = 1'b0;
  logic [7:0]  cfg_data = 8'h00;

  can_frame_text_line_parser dut (.*);

  always #5 clk = ~clk;

  // model state
  logic [2:0]  m_dport;
  logic [7:0]  m_flood;
  cftlp_pkg::phase_t m_ph;
  int unsigned m_dc, m_ida, m_idb, m_pcnt, m_nib, m_chk, m_cnt;
  logic        m_ext, m_rtr, m_err;
  logic [63:0] m_pay;
  logic [2:0]  m_port;

  frame_res_t  frames_due[$];
  logic        exp_fixed[$];
  frame_res_t  exp_typed[$];
  int          fails = 0;
  longint      cycles = 0;
  int          stall_len = 0;
  bit          quiet_out = 0;

  function automatic int hexv(logic [8:0] c);
    if (c >= "0" && c <= "9") return c - "0";
    if (c >= "a" && c <= "f") return c - "a" + 10;
    if (c >= "A" && c <= "F") return c - "A" + 10;
    return -1;
  endfunction

  function automatic int unsigned acc(int unsigned v, int d, int unsigned lim);
    if (v > lim) return v;
    v = (v << 4) | d;
    return v > lim ? lim + 1 : v;
  endfunction

  function automatic logic [15:0] crc8(logic [15:0] crc, logic [7:0] b);
    crc ^= {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (crc[15]) crc ^= 16'hc599;
      crc = crc << 1;
    end
    return crc;
  endfunction

  function automatic logic [31:0] hdr_word();
    return {m_ida[10:0], m_idb[17:0], m_ext, m_rtr, 1'b0};
  endfunction

  task automatic line_reset();
    m_ph = cftlp_pkg::PH_IDA; m_dc = 0; m_ida = 0; m_idb = 0; m_ext = 0; m_rtr = 0;
    m_pay = '0; m_pcnt = 0; m_nib = 0; m_chk = 0; m_port = m_dport;
    m_err = 0; m_cnt = 0;
  endtask

  task automatic parse_char(logic [8:0] c);
    int d;
    logic [31:0] h;
    logic [15:0] crc;
    forever begin
      d = hexv(c);
      case (m_ph)
        cftlp_pkg::PH_IDA: begin
          if (d >= 0 && m_dc < 8) begin
            m_ida = acc(m_ida, d, 'h7ff); m_dc++; return;
          end
          if (m_dc == 0 || m_ida == 0 || m_ida > 'h7ff) begin
            m_ph = cftlp_pkg::PH_ERR; m_err = 1; return;
          end
          if (c == ".") begin m_ph = cftlp_pkg::PH_IDB; m_dc = 0; return; end
          m_ph = cftlp_pkg::PH_AFTER_IDB;
        end
        cftlp_pkg::PH_IDB: begin
          if (d >= 0 && m_dc < 8) begin
            m_idb = acc(m_idb, d, 'h3ffff); m_dc++; return;
          end
          if (m_dc == 0 || m_idb > 'h3ffff) begin
            m_ph = cftlp_pkg::PH_ERR; m_err = 1; return;
          end
          m_ext = 1; m_ph = cftlp_pkg::PH_AFTER_IDB;
        end
        cftlp_pkg::PH_AFTER_IDB: begin
          m_ph = cftlp_pkg::PH_AFTER_R;
          if (c == "R") begin m_rtr = 1; return; end
        end
        cftlp_pkg::PH_AFTER_R: begin
          if (c == ":") begin m_ph = cftlp_pkg::PH_PAY; return; end
          m_ph = cftlp_pkg::PH_AFTER_PAY;
        end
        cftlp_pkg::PH_PAY: begin
          if (m_nib[4]) begin
            if (d < 0) begin m_ph = cftlp_pkg::PH_ERR; m_err = 1; return; end
            m_pay |= 64'({m_nib[3:0], d[3:0]}) << ((m_pcnt & 7) * 8);
            m_pcnt++; m_nib = 0; return;
          end
          if (d >= 0) begin
            if (m_pcnt >= 8) begin m_ph = cftlp_pkg::PH_ERR; m_err = 1; return; end
            m_nib = 'h10 | d; return;
          end
          m_ph = cftlp_pkg::PH_AFTER_PAY;
        end
        cftlp_pkg::PH_AFTER_PAY: begin
          if (c == ":") begin
            m_ph = cftlp_pkg::PH_CHK; m_dc = 0; m_chk = 0; return;
          end
          m_ph = cftlp_pkg::PH_AFTER_CHK;
        end
        cftlp_pkg::PH_CHK: begin
          if (d >= 0) begin
            if (m_dc >= 4) begin m_ph = cftlp_pkg::PH_ERR; m_err = 1; return; end
            m_chk = ((m_chk << 4) | d) & 'hffff; m_dc++; return;
          end
          if (m_dc != 4) begin m_ph = cftlp_pkg::PH_ERR; m_err = 1; return; end
          h = hdr_word();
          crc = 0;
          for (int k = 3; k >= 0; k--) crc = crc8(crc, h[k*8 +: 8]);
          for (int k = 0; k < m_pcnt && k < 8; k++) crc = crc8(crc, m_pay[k*8 +: 8]);
          crc = crc8(crc, m_chk[15:8]);
          crc = crc8(crc, m_chk[7:0]);
          if (crc != 0) begin m_ph = cftlp_pkg::PH_ERR; m_err = 1; return; end
          m_ph = cftlp_pkg::PH_AFTER_CHK;
        end
        cftlp_pkg::PH_AFTER_CHK: begin
          m_ph = (c == " ") ? cftlp_pkg::PH_PORT : cftlp_pkg::PH_DONE; return;
        end
        cftlp_pkg::PH_PORT: begin
          if (c >= "0" && c <= "7") m_port = c[2:0];
          m_ph = cftlp_pkg::PH_DONE; return;
        end
        default: return;
      endcase
    end
  endtask

  function automatic frame_res_t make_res(logic [1:0] st, int unsigned n);
    frame_res_t r;
    logic ok;
    ok = (st == cftlp_pkg::StatusOk);
    r.status = st;
    r.port = ok ? m_port : m_dport;
    r.header = ok ? hdr_word() : '0;
    r.payload_len = ok ? m_pcnt[3:0] : '0;
    r.payload = ok ? m_pay : '0;
    r.line_bytes = n[8:0];
    return r;
  endfunction

  // returns 1 and the result when the byte completes a line or a flood
  task automatic predict_byte(logic [7:0] c, output bit got, output frame_res_t r);
    got = 0;
    if (c == 8'h0a || c == 8'h0d) begin
      if (m_cnt == 0) return;
      parse_char(9'h100);
      r = make_res(m_err ? cftlp_pkg::StatusError : cftlp_pkg::StatusOk, m_cnt + 1);
      line_reset(); got = 1; return;
    end
    if (m_cnt == 0) line_reset();
    m_cnt++;
    parse_char({1'b0, c});
    if (m_cnt > m_flood) begin
      r = make_res(cftlp_pkg::StatusFlood, m_cnt);
      line_reset(); got = 1;
    end
  endtask

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // valid stays high into the next transaction when there is no gap
  task automatic send_byte(logic [7:0] c, bit has_exp, frame_res_t er);
    bit got;
    frame_res_t r;
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    predict_byte(c, got, r);
    if (got) begin
      frames_due.push_back(r);
      exp_fixed.push_back(has_exp);
      exp_typed.push_back(er);
    end
    in_valid <= 1'b1;
    in_byte <= c;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_text(string s);
    frame_res_t nr;
    nr = '{default: '0};
    for (int i = 0; i < s.len(); i++) send_byte(s[i], 1'b0, nr);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [7:0] val);
    cfg_valid <= 1'b1; cfg_index <= idx; cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == cftlp_pkg::RegDefaultPort) m_dport = val[2:0];
    else m_flood = val;
    @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (frames_due.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  // builds a line with no check or a valid or broken one; some get a corrupted byte
  function automatic string rand_line();
    string s, t;
    logic [31:0] h;
    logic [15:0] crc, chk;
    int unsigned a, b, n;
    logic [7:0] pb[8];
    bit ext, rtr, use_chk;
    a = $urandom_range(1, 'h7ff);
    b = $urandom_range(0, 'h3ffff);
    ext = ($urandom_range(0, 1) == 1);
    rtr = $urandom_range(0, 3) == 0;
    n = $urandom_range(0, 8);
    use_chk = $urandom_range(0, 3) != 0;
    s = $urandom_range(0, 1) ? $sformatf("%0h", a) : $sformatf("%0H", a);
    if (ext) s = {s, $sformatf(".%05h", b)};
    if (rtr) s = {s, "R"};
    h = {a[10:0], ext ? b[17:0] : 18'd0, ext, rtr, 1'b0};
    crc = 0;
    for (int k = 3; k >= 0; k--) crc = crc8(crc, h[k*8 +: 8]);
    if (n > 0 || use_chk) begin
      s = {s, ":"};
      for (int k = 0; k < n; k++) begin
        pb[k] = 8'($urandom);
        s = {s, $sformatf("%02h", pb[k])};
        crc = crc8(crc, pb[k]);
      end
    end
    if (use_chk) begin
      // running remainder over header and payload is the check word
      chk = crc;
      if ($urandom_range(0, 9) == 0) chk ^= 16'(1 << $urandom_range(0, 15));
      s = {s, $sformatf(":%04h", chk)};
    end
    if ($urandom_range(0, 1)) begin
      t = $sformatf(" %0d", $urandom_range(0, 9));
      s = {s, t};
      if ($urandom_range(0, 4) == 0) s = {s, "xyz"};
    end
    if ($urandom_range(0, 15) == 0 && s.len() > 2)
      s[$urandom_range(0, s.len() - 1)] = 8'($urandom);
    return s;
  endfunction

  // sink: random stalls, comparison with the oldest expectation
  always @(posedge clk) begin
    frame_res_t e, t;
    logic fx;
    cycles <= cycles + 1;
    if (!rst && out_valid && !out_stall) begin
      if (frames_due.size() == 0) begin
        $display("%0t: unexpected result status %0d", $time, status);
        fails = fails + 1;
      end else begin
        e = frames_due.pop_front();
        fx = exp_fixed.pop_front();
        t = exp_typed.pop_front();
        if (fx && t != e) begin
          $display("%0t: typed expectation disagrees with model", $time);
          fails = fails + 1;
        end
        if (status !== e.status || port !== e.port || header !== e.header ||
            payload_len !== e.payload_len || payload !== e.payload ||
            line_bytes !== e.line_bytes) begin
          $display("%0t: mismatch expected st=%0d port=%0d hdr=%h len=%0d pay=%h n=%0d",
                   $time, e.status, e.port, e.header, e.payload_len, e.payload,
                   e.line_bytes);
          $display("%0t:          actual st=%0d port=%0d hdr=%h len=%0d pay=%h n=%0d",
                   $time, status, port, header, payload_len, payload, line_bytes);
          fails = fails + 1;
        end
      end
    end
    if (stall_len > 0) begin
      stall_len <= stall_len - 1;
      out_stall <= 1'b1;
    end else if (!quiet_out && $urandom_range(0, 3) == 0) begin
      stall_len <= gap_len();
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
    if (cycles > 3000000) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  row_t dir_rows[$];

  function automatic frame_res_t fr(logic [1:0] st, logic [2:0] p, int unsigned n);
    frame_res_t r;
    r = '{default: '0};
    r.status = st; r.port = p; r.line_bytes = n[8:0];
    return r;
  endfunction

  task automatic add_rows(string s, bit has_exp, frame_res_t r);
    frame_res_t nr;
    nr = '{default: '0};
    for (int i = 0; i < s.len(); i++)
      dir_rows.push_back('{s[i], (i == s.len() - 1) ? has_exp : 1'b0,
                           (i == s.len() - 1) ? r : nr});
  endtask

  initial begin
    frame_res_t nr, ok1;
    string s;
    int items;
    nr = '{default: '0};
    m_dport = 3; m_flood = 96;
    line_reset();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed rows
    add_rows("\r\n", 0, nr);                             // empty lines
    ok1 = fr(cftlp_pkg::StatusOk, 3, 4);
    ok1.header = 32'h7ff << 21;
    add_rows("7ff\n", 1, ok1);
    add_rows("0\r", 1, fr(cftlp_pkg::StatusError, 3, 2));           // zero id
    add_rows("800\n", 1, fr(cftlp_pkg::StatusError, 3, 4));         // id too big
    add_rows(".5\n", 1, fr(cftlp_pkg::StatusError, 3, 3));
    add_rows("1.40000\n", 1, fr(cftlp_pkg::StatusError, 3, 8));     // id_b too big
    add_rows("1.3ffffR:0011223344556677 7\r\n", 0, nr);
    add_rows("000000001234\n", 0, nr);                              // long digit run
    add_rows("1:001122334455667788\n", 1, fr(cftlp_pkg::StatusError, 3, 21));
    add_rows("1:abc\n", 1, fr(cftlp_pkg::StatusError, 3, 6));       // lone nibble
    add_rows("1::12\n", 1, fr(cftlp_pkg::StatusError, 3, 6));       // short check
    add_rows("1::FFFFF\n", 1, fr(cftlp_pkg::StatusError, 3, 9));
    add_rows({8'hff, 8'h80, "\n"}, 1, fr(cftlp_pkg::StatusError, 3, 3));
    foreach (dir_rows[i]) send_byte(dir_rows[i].ch, dir_rows[i].has_exp, dir_rows[i].res);
    drain();

    write_reg(cftlp_pkg::RegDefaultPort, 8'd0);
    write_reg(cftlp_pkg::RegFloodLimit, 8'd1);
    send_text("ab\n7\nzz\n");
    drain();
    write_reg(cftlp_pkg::RegDefaultPort, 8'd7);
    write_reg(cftlp_pkg::RegFloodLimit, 8'd255);
    for (int i = 0; i < 300; i++) send_byte(8'h41, 0, nr);
    send_text("\n");
    drain();

    items = 0;
    for (int ph = 0; ph < 4; ph++) begin
      write_reg(cftlp_pkg::RegDefaultPort, 8'($urandom_range(0, 7)));
      write_reg(cftlp_pkg::RegFloodLimit, (ph == 3) ? 8'($urandom_range(1, 20)) :
                                                       8'($urandom_range(40, 255)));
      quiet_out = (ph == 1);
      while (items < (ph + 1) * 320) begin
        if ($urandom_range(0, 9) < 8) begin
          s = rand_line();
          send_text(s);
          items += s.len();
          send_text($urandom_range(0, 1) ? "\n" : "\r\n");
        end else begin
          send_byte(8'($urandom), 0, nr);
        end
        items++;
      end
      drain();
    end
    quiet_out = 0;
    drain();
    if (fails == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end
endmodule
